// File: sv/swi_pkg.sv
`default_nettype none
package swi_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned NumIn    = 8;
  localparam int unsigned InDataW  = CoordW * NumIn;
  // hit, hit_x, hit_z packed, padded to whole bytes
  localparam int unsigned OutBits  = 1 + 2 * CoordW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;
  localparam int unsigned FracW    = 16;
  // quotient covers 0 .. 1.0 in 1.16, so 17 bits
  localparam int unsigned QuoW     = FracW + 1;
  localparam int unsigned DivSteps = QuoW;

  typedef struct packed {
    logic                     hit;
    logic [CoordW:0]          rem;
    logic [CoordW-1:0]        dvs;
    logic [QuoW-1:0]          quo;
    logic signed [CoordW-1:0] px0;
    logic signed [CoordW-1:0] pz0;
    logic signed [CoordW-1:0] pdx;
    logic signed [CoordW-1:0] pdz;
  } div_stage_t;

endpackage
`default_nettype wire

// File: sv/segment_wall_intersection.sv
// throughput: one beat per cycle unless the output beat waits; the
// 17-step restoring divider is fully pipelined, one quotient bit per
// stage, so every stage advances together
// reset: rst_ni clears all stage valid bits, no payload is cleared
// while the output beat waits, the whole pipeline holds
`default_nettype none
module segment_wall_intersection (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // path_start_x, path_start_z, path_end_x, path_end_z,
  // wall_first_x, wall_first_z, wall_second_x, wall_second_z
  input  wire logic [swi_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // hit, hit_x, hit_z, zero padding
  output logic [swi_pkg::OutDataW-1:0]          m_axis_tdata
);
  import swi_pkg::*;

  localparam int unsigned W = CoordW;

  logic en;

  // input register
  logic                v1_q;
  logic signed [W-1:0] px0_1_q, pz0_1_q, px1_1_q, pz1_1_q;
  logic signed [W-1:0] wx0_1_q, wz0_1_q, wx1_1_q, wz1_1_q;

  // differences and bounding rejections
  logic                v2_q, rej2_q, rej2_d;
  logic signed [W-1:0] pdx2_q, pdz2_q, wdx2_q, wdz2_q, xo2_q, zo2_q;
  logic signed [W-1:0] pdx2_d, pdz2_d, wdx2_d, wdz2_d, xo2_d, zo2_d;
  logic signed [W-1:0] px0_2_q, pz0_2_q;

  // products
  logic                v3_q, rej3_q;
  logic signed [W-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [2*W-1:0] m0_d, m1_d, m2_d, m3_d, m4_d, m5_d;
  logic signed [W-1:0] px0_3_q, pz0_3_q, pdx3_q, pdz3_q;

  // numerators and denominator
  logic                v4_q, rej4_q;
  logic signed [W-1:0] num4_q, den4_q, nm2_4_q;
  logic signed [W-1:0] px0_4_q, pz0_4_q, pdx4_q, pdz4_q;

  // divider pipeline
  logic       div_vld_q [DivSteps+1];
  div_stage_t div_q     [DivSteps+1];
  div_stage_t div_d     [DivSteps+1];

  // scaling products
  logic                  v6_q, hit6_q;
  logic signed [W-1:0]   tx6_q, tz6_q, px0_6_q, pz0_6_q;
  logic signed [W+QuoW:0] tx6_d, tz6_d;

  // output register
  logic                out_vld_q;
  logic                hit_q;
  logic signed [W-1:0] hx_q, hz_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-OutBits){1'b0}}, hz_q, hx_q, hit_q};

  // differences and range rejections
  always_comb begin
    logic signed [W-1:0] lo, hi;
    logic xrej, zrej;
    pdx2_d = px1_1_q - px0_1_q;
    wdx2_d = wx0_1_q - wx1_1_q;
    pdz2_d = pz1_1_q - pz0_1_q;
    wdz2_d = wz0_1_q - wz1_1_q;
    xo2_d  = px0_1_q - wx0_1_q;
    zo2_d  = pz0_1_q - wz0_1_q;
    if (pdx2_d < 0) begin
      lo = px1_1_q; hi = px0_1_q;
    end else begin
      lo = px0_1_q; hi = px1_1_q;
    end
    if (wdx2_d > 0) begin
      xrej = (hi < wx1_1_q) || (wx0_1_q < lo);
    end else begin
      xrej = (hi < wx0_1_q) || (wx1_1_q < lo);
    end
    if (pdz2_d < 0) begin
      lo = pz1_1_q; hi = pz0_1_q;
    end else begin
      lo = pz0_1_q; hi = pz1_1_q;
    end
    // asymmetric z test
    zrej = ((wdz2_d > 0) && (hi < wz1_1_q)) ||
           ((wz0_1_q < lo) && ((hi < wz0_1_q) || (wz1_1_q < lo)));
    rej2_d = xrej || zrej;
  end

  // six cross products
  always_comb begin
    m0_d = wdz2_q * xo2_q;
    m1_d = wdx2_q * zo2_q;
    m2_d = pdz2_q * wdx2_q;
    m3_d = pdx2_q * wdz2_q;
    m4_d = pdx2_q * zo2_q;
    m5_d = pdz2_q * xo2_q;
  end

  // hit decision, divider entry and one quotient bit per stage
  always_comb begin
    logic       hit;
    logic [W:0] rs;
    logic       ge;
    hit = !rej4_q && (den4_q < 0) && (num4_q <= 0) && (num4_q >= den4_q) &&
          (nm2_4_q <= 0) && (nm2_4_q >= den4_q);
    div_d[0].hit = hit;
    div_d[0].rem = {1'b0, W'(-num4_q)};
    div_d[0].dvs = W'(-den4_q);
    div_d[0].quo = '0;
    div_d[0].px0 = px0_4_q;
    div_d[0].pz0 = pz0_4_q;
    div_d[0].pdx = pdx4_q;
    div_d[0].pdz = pdz4_q;
    for (int k = 0; k < DivSteps; k++) begin
      rs = (k == 0) ? div_q[k].rem : {div_q[k].rem[W-1:0], 1'b0};
      ge = rs >= {1'b0, div_q[k].dvs};
      div_d[k+1]     = div_q[k];
      div_d[k+1].rem = ge ? rs - {1'b0, div_q[k].dvs} : rs;
      div_d[k+1].quo = {div_q[k].quo[QuoW-2:0], ge};
    end
  end

  // t times path delta
  always_comb begin
    tx6_d = $signed({1'b0, div_q[DivSteps].quo}) * div_q[DivSteps].pdx;
    tz6_d = $signed({1'b0, div_q[DivSteps].quo}) * div_q[DivSteps].pdz;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v6_q <= 1'b0; out_vld_q <= 1'b0;
      for (int k = 0; k <= DivSteps; k++) div_vld_q[k] <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      div_vld_q[0] <= v4_q;
      for (int k = 1; k <= DivSteps; k++) div_vld_q[k] <= div_vld_q[k-1];
      v6_q      <= div_vld_q[DivSteps];
      out_vld_q <= v6_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      px0_1_q <= s_axis_tdata[0*W +: W];
      pz0_1_q <= s_axis_tdata[1*W +: W];
      px1_1_q <= s_axis_tdata[2*W +: W];
      pz1_1_q <= s_axis_tdata[3*W +: W];
      wx0_1_q <= s_axis_tdata[4*W +: W];
      wz0_1_q <= s_axis_tdata[5*W +: W];
      wx1_1_q <= s_axis_tdata[6*W +: W];
      wz1_1_q <= s_axis_tdata[7*W +: W];

      pdx2_q <= pdx2_d; pdz2_q <= pdz2_d; wdx2_q <= wdx2_d; wdz2_q <= wdz2_d;
      xo2_q  <= xo2_d;  zo2_q  <= zo2_d;  rej2_q <= rej2_d;
      px0_2_q <= px0_1_q; pz0_2_q <= pz0_1_q;

      m0_q <= m0_d[FracW +: W]; m1_q <= m1_d[FracW +: W];
      m2_q <= m2_d[FracW +: W]; m3_q <= m3_d[FracW +: W];
      m4_q <= m4_d[FracW +: W]; m5_q <= m5_d[FracW +: W];
      rej3_q <= rej2_q;
      px0_3_q <= px0_2_q; pz0_3_q <= pz0_2_q; pdx3_q <= pdx2_q; pdz3_q <= pdz2_q;

      num4_q  <= m0_q - m1_q;
      den4_q  <= m2_q - m3_q;
      nm2_4_q <= m4_q - m5_q;
      rej4_q  <= rej3_q;
      px0_4_q <= px0_3_q; pz0_4_q <= pz0_3_q; pdx4_q <= pdx3_q; pdz4_q <= pdz3_q;

      for (int k = 0; k <= DivSteps; k++) div_q[k] <= div_d[k];

      tx6_q   <= tx6_d[FracW +: W];
      tz6_q   <= tz6_d[FracW +: W];
      hit6_q  <= div_q[DivSteps].hit;
      px0_6_q <= div_q[DivSteps].px0;
      pz0_6_q <= div_q[DivSteps].pz0;

      hit_q <= hit6_q;
      hx_q  <= hit6_q ? px0_6_q + tx6_q : '0;
      hz_q  <= hit6_q ? pz0_6_q + tz6_q : '0;
    end
  end

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !hit_q |-> (hx_q == '0) && (hz_q == '0))
    else $error("miss beat with nonzero point");

  // divider entry remainder never exceeds the divisor on a hit
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld_q[0] && div_q[0].hit |-> div_q[0].rem <= {1'b0, div_q[0].dvs})
    else $error("divider entry out of range");

  // quotient stays within one in 16.16
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld_q[DivSteps] && div_q[DivSteps].hit |->
      div_q[DivSteps].quo <= QuoW'(1 << FracW))
    else $error("quotient above one");

  // a stalled output beat keeps its hit flag and hit_x
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> out_vld_q && $stable(hit_q) && $stable(hx_q))
    else $error("output beat changed under stall");

endmodule
`default_nettype wire
